@@ design/pq4_pkg.sv @@
// shared types and constants for the 4-bit pq lookup-and-accumulate block
// no dependencies; used by pq4_lane, pq4_merge and the top level
package pq4_pkg;

    localparam int LANES       = 32;
    localparam int HALF_LANES  = 16;
    localparam int TABLE_BYTES = 16;
    localparam int BYTE_W      = 8;
    localparam int NIBBLE_W    = 4;
    localparam int LANE_IDX_W  = 5;
    localparam int LANE_SUM_W  = 16;

    // 16 table bytes, byte i at bits 8i+7:8i of {table_high, table_low}
    typedef logic [TABLE_BYTES-1:0][BYTE_W-1:0] table_t;

    typedef struct packed {
        logic [63:0] table_low;
        logic [63:0] table_high;
        logic [63:0] codes_low;
        logic [63:0] codes_high;
        logic        last_segment;
    } seg_word_t;

    typedef struct packed {
        logic [LANE_IDX_W-1:0] lane_index;
        logic [LANE_SUM_W-1:0] lane_sum;
        logic                  last_lane;
    } res_word_t;

    // per-segment control driven to every lane
    typedef struct packed {
        logic acc_en;   // a segment word is accepted this cycle
        logic clear;    // that word closes the run
    } lane_ctrl_t;

    // handshake between the top level and the output bank
    typedef struct packed {
        logic load;     // capture the final lane sums
    } merge_ctrl_t;

    typedef struct packed {
        logic busy;     // bank still holds sums that are not all delivered
    } merge_stat_t;

endpackage

@@ design/pq4_lane.sv @@
// one scoring lane: nibble-selected table byte added into an accumulator
// depends on pq4_pkg
module pq4_lane #(
    parameter int ACC_WIDTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pq4_pkg::lane_ctrl_t       ctrl,
    input  pq4_pkg::table_t           table_bytes,
    input  logic [pq4_pkg::NIBBLE_W-1:0] code,
    output logic [ACC_WIDTH-1:0]      sum
);

    logic [ACC_WIDTH-1:0]          acc_reg;
    logic [ACC_WIDTH-1:0]          acc_next;
    logic [pq4_pkg::BYTE_W-1:0]    pick;

    assign pick = table_bytes[code];
    // running sum including this segment, wraps at the accumulator width
    assign sum  = acc_reg + {{(ACC_WIDTH-pq4_pkg::BYTE_W){1'b0}}, pick};

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_next = sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

@@ design/pq4_merge.sv @@
// output bank: captures the 32 final lane sums and sends them in lane order
// depends on pq4_pkg
module pq4_merge #(
    parameter int ACC_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pq4_pkg::merge_ctrl_t  ctrl,
    input  logic [ACC_WIDTH-1:0]  sums [pq4_pkg::LANES],
    output pq4_pkg::merge_stat_t  stat,
    output logic                  res_valid,
    input  logic                  res_stall,
    output pq4_pkg::res_word_t    res
);

    localparam logic [pq4_pkg::LANE_IDX_W-1:0] LAST_IDX =
        pq4_pkg::LANE_IDX_W'(pq4_pkg::LANES - 1);

    logic [pq4_pkg::LANE_SUM_W-1:0] sum_trunc [pq4_pkg::LANES];
    logic [pq4_pkg::LANE_SUM_W-1:0] bank_reg  [pq4_pkg::LANES];
    logic [pq4_pkg::LANE_IDX_W-1:0] idx_reg;
    logic [pq4_pkg::LANE_IDX_W-1:0] idx_next;
    logic                           busy_reg;
    logic                           busy_next;
    logic                           res_take;

    // low 16 bits of each accumulator, zero-extended for narrow ones
    for (genvar j = 0; j < pq4_pkg::LANES; j++)
    begin : g_trunc
        if (ACC_WIDTH >= pq4_pkg::LANE_SUM_W)
        begin : g_cut
            assign sum_trunc[j] = sums[j][pq4_pkg::LANE_SUM_W-1:0];
        end
        else
        begin : g_ext
            assign sum_trunc[j] = {{(pq4_pkg::LANE_SUM_W-ACC_WIDTH){1'b0}}, sums[j]};
        end
    end

    assign res_take = busy_reg && !res_stall;

    always_comb
    begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (ctrl.load)
        begin
            idx_next  = '0;
            busy_next = 1'b1;
        end
        else if (res_take)
        begin
            if (idx_reg == LAST_IDX)
            begin
                idx_next  = '0;
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            for (int j = 0; j < pq4_pkg::LANES; j++)
            begin
                bank_reg[j] <= sum_trunc[j];
            end
        end
    end

    assign stat.busy      = busy_reg;
    assign res_valid      = busy_reg;
    assign res.lane_index = idx_reg;
    assign res.lane_sum   = bank_reg[idx_reg];
    assign res.last_lane  = (idx_reg == LAST_IDX);

    // bank is never reloaded while words are still pending
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |-> !busy_reg)
        else $error("bank loaded while busy");

    a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> (busy_reg && idx_reg == '0))
        else $error("drain did not start at lane 0");

    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res_take && idx_reg == LAST_IDX) |=> !busy_reg)
        else $error("bank still busy after lane 31 delivered");

    a_hold_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && res_stall) |=> $stable(idx_reg))
        else $error("lane index moved while stalled");

endmodule

@@ design/pq4_lut_accumulate_block32_core.sv @@
// top level of the 32-lane 4-bit pq lookup-and-accumulate block
// depends on pq4_pkg, pq4_lane, pq4_merge
//
// usage
//   seg channel: one word per table segment (16 table bytes, 16 code bytes,
//     last_segment flag). code byte j feeds lane j from its low nibble and
//     lane j+16 from its high nibble; each nibble picks a table byte that
//     is added into that lane's accumulator
//   res channel: after a word with last_segment set, 32 words follow, one
//     per lane in order 0..31, last_lane set on lane 31
//   throughput: one segment word per unstalled cycle; 32 lanes add at once
//   latency: lane 0 sum shows on res the cycle after the last segment is
//     taken; the remaining lanes follow in order as res takes them
//   the 32 sums are copied into an output bank, so further segments of the
//     next run keep streaming while the bank drains; only a second
//     last_segment word is held off (seg_stall) until lane 31 is taken
//   res stall: the current result word holds until taken
//   reset: accumulators clear to zero, output bank goes empty
module pq4_lut_accumulate_block32_core #(
    parameter int ACC_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                seg_valid,
    output logic                seg_stall,
    input  pq4_pkg::seg_word_t  seg,
    output logic                res_valid,
    input  logic                res_stall,
    output pq4_pkg::res_word_t  res
);

    pq4_pkg::table_t              table_bytes;
    logic [127:0]                 codes;
    pq4_pkg::lane_ctrl_t          lane_ctrl;
    pq4_pkg::merge_ctrl_t         merge_ctrl;
    pq4_pkg::merge_stat_t         merge_stat;
    logic [ACC_WIDTH-1:0]         lane_sums [pq4_pkg::LANES];
    logic                         seg_take;

    // hold off a closing segment while the previous run is still draining
    assign seg_stall = seg_valid && seg.last_segment && merge_stat.busy;
    assign seg_take  = seg_valid && !seg_stall;

    assign table_bytes = {seg.table_high, seg.table_low};
    assign codes       = {seg.codes_high, seg.codes_low};

    assign lane_ctrl.acc_en = seg_take;
    assign lane_ctrl.clear  = seg_take && seg.last_segment;
    // bank captures sums that already include the closing segment
    assign merge_ctrl.load  = seg_take && seg.last_segment;

    // lanes 0..15 read low nibbles, lanes 16..31 the high nibbles
    for (genvar j = 0; j < pq4_pkg::LANES; j++)
    begin : g_lane
        localparam int BYTE_POS = (j % pq4_pkg::HALF_LANES) * pq4_pkg::BYTE_W;
        localparam int NIB_POS  = BYTE_POS
                                + ((j >= pq4_pkg::HALF_LANES) ? pq4_pkg::NIBBLE_W : 0);

        pq4_lane #(
            .ACC_WIDTH (ACC_WIDTH)
        ) u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (lane_ctrl),
            .table_bytes (table_bytes),
            .code        (codes[NIB_POS +: pq4_pkg::NIBBLE_W]),
            .sum         (lane_sums[j])
        );
    end

    pq4_merge #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (merge_ctrl),
        .sums      (lane_sums),
        .stat      (merge_stat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

@@ test/pq4_lut_accumulate_block32_core_test.sv @@
// self-checking testbench for the 32-lane 4-bit pq lookup-and-accumulate block
// depends on pq4_pkg and pq4_lut_accumulate_block32_core; directed table, then random runs
// every result word is checked against a lane accumulator predictor kept in this file
module pq4_lut_accumulate_block32_core_test;

    localparam int RUN_LIMIT    = 1000000; // cycles before the run is called hung
    localparam int DRAIN_CYCLES = 64;      // quiet time after the last result is due
    localparam int RANDOM_ITEMS = 340;     // segment words in the random part
    localparam int LONG_RUN     = 270;     // one run this long forces accumulator wrap

    // one directed stimulus row; typed rows carry the sums read straight off the
    // segment, split into lanes 0..15 and lanes 16..31
    typedef struct {
        pq4_pkg::seg_word_t word;
        bit                 typed;
        logic [15:0]        low_half_sum;
        logic [15:0]        high_half_sum;
    } plan_row_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               seg_valid = 1'b0;
    logic               seg_stall;
    pq4_pkg::seg_word_t seg       = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    pq4_pkg::res_word_t res;

    // predictor state: one running sum per lane, wrapping at 16 bits
    logic [pq4_pkg::LANE_SUM_W-1:0] lane_totals [pq4_pkg::LANES];
    // lane sums still owed by the block, oldest first
    pq4_pkg::res_word_t             lane_sums_due [$];
    plan_row_t                      plan [$];

    int errors      = 0;
    int cycle_count = 0;
    int burst_left  = 0;
    int stall_span  = 0;
    int stall_mode  = 0;

    pq4_lut_accumulate_block32_core #(
        .ACC_WIDTH (16)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (seg_valid),
        .seg_stall (seg_stall),
        .seg       (seg),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // add one accepted segment into the lane sums; on a last segment queue
    // the 32 sums in lane order and clear them
    task automatic score_segment(input pq4_pkg::seg_word_t w, input bit typed,
                                 input logic [15:0] low_sum, input logic [15:0] high_sum);
        logic [pq4_pkg::BYTE_W-1:0] tbytes [pq4_pkg::TABLE_BYTES];
        logic [pq4_pkg::BYTE_W-1:0] code;
        pq4_pkg::res_word_t         r;
        for (int i = 0; i < 8; i++)
        begin
            tbytes[i]     = w.table_low[8*i +: 8];
            tbytes[i + 8] = w.table_high[8*i +: 8];
        end
        for (int j = 0; j < pq4_pkg::HALF_LANES; j++)
        begin
            // code byte j: low nibble feeds lane j, high nibble lane j+16
            code = (j < 8) ? w.codes_low[8*j +: 8] : w.codes_high[8*(j-8) +: 8];
            lane_totals[j] = lane_totals[j]
                           + pq4_pkg::LANE_SUM_W'(tbytes[code[3:0]]);
            lane_totals[j + pq4_pkg::HALF_LANES] =
                lane_totals[j + pq4_pkg::HALF_LANES]
                + pq4_pkg::LANE_SUM_W'(tbytes[code[7:4]]);
        end
        if (w.last_segment)
        begin
            for (int lane = 0; lane < pq4_pkg::LANES; lane++)
            begin
                r.lane_index = pq4_pkg::LANE_IDX_W'(lane);
                if (typed)
                    r.lane_sum = (lane < pq4_pkg::HALF_LANES) ? low_sum : high_sum;
                else
                    r.lane_sum = lane_totals[lane];
                r.last_lane = (lane == pq4_pkg::LANES - 1);
                lane_sums_due = {lane_sums_due, r};
                lane_totals[lane] = '0;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic add_row(input logic [63:0] tab_lo, input logic [63:0] tab_hi,
                           input logic [63:0] code_lo, input logic [63:0] code_hi,
                           input bit last, input bit typed,
                           input logic [15:0] low_sum, input logic [15:0] high_sum);
        plan_row_t row;
        row.word.table_low    = tab_lo;
        row.word.table_high   = tab_hi;
        row.word.codes_low    = code_lo;
        row.word.codes_high   = code_hi;
        row.word.last_segment = last;
        row.typed             = typed;
        row.low_half_sum      = low_sum;
        row.high_half_sum     = high_sum;
        plan = {plan, row};
    endtask

    // random segment content; heavy forces every table byte to 0xf8 or more
    // so that a long run is sure to wrap the 16-bit sums
    function automatic pq4_pkg::seg_word_t random_segment(input bit last, input bit heavy);
        pq4_pkg::seg_word_t w;
        w.table_low    = {$urandom, $urandom};
        w.table_high   = {$urandom, $urandom};
        w.codes_low    = {$urandom, $urandom};
        w.codes_high   = {$urandom, $urandom};
        w.last_segment = last;
        case ($urandom_range(0, 7))
            0:
            begin
                w.codes_low  = '0;
                w.codes_high = '0;
            end
            1:
            begin
                w.codes_low  = '1;
                w.codes_high = '1;
            end
            2:
            begin
                w.table_low  = '0;
                w.table_high = '0;
            end
            3:
            begin
                w.table_low  = '1;
                w.table_high = '1;
            end
            default: ;
        endcase
        if (heavy)
        begin
            w.table_low  = w.table_low  | 64'hF8F8_F8F8_F8F8_F8F8;
            w.table_high = w.table_high | 64'hF8F8_F8F8_F8F8_F8F8;
        end
        return w;
    endfunction

    // present one segment word at the falling edge and hold it until taken;
    // the sender runs in bursts of random length with random gaps between
    // them, and the payload is scrambled while valid is low
    task automatic send_word(input pq4_pkg::seg_word_t w, input bit typed,
                             input logic [15:0] low_sum, input logic [15:0] high_sum);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 6);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                seg_valid <= 1'b0;
                seg       <= random_segment(1'($urandom_range(0, 1)), 1'b0);
                repeat (gap) @(negedge clk);
            end
        end
        seg_valid <= 1'b1;
        seg       <= w;
        // seg_stall read here is the value from just before the edge
        @(posedge clk);
        while (seg_stall)
            @(posedge clk);
        score_segment(w, typed, low_sum, high_sum);
        burst_left--;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // receiver: stall pattern switches between free flow, coin toss and
    // mostly stalled, each kept for a random stretch
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_span = $urandom_range(16, 80);
        end
        stall_span--;
        case (stall_mode)
            0:       res_stall <= 1'b0;
            1:       res_stall <= 1'($urandom_range(0, 1));
            default: res_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // ------------------------------------------------------------------
    // result checker: every taken word against the oldest sum due
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        pq4_pkg::res_word_t due;
        if (rst_n && res_valid && !res_stall)
        begin
            if (lane_sums_due.size() == 0)
            begin
                errors++;
                $display("%0t: result word with nothing due: lane %0d sum %h last %b",
                         $time, res.lane_index, res.lane_sum, res.last_lane);
            end
            else
            begin
                due = lane_sums_due.pop_front();
                if (res.lane_index !== due.lane_index)
                begin
                    errors++;
                    $display("%0t: lane_index expected %0d got %0d",
                             $time, due.lane_index, res.lane_index);
                end
                if (res.lane_sum !== due.lane_sum)
                begin
                    errors++;
                    $display("%0t: lane %0d lane_sum expected %h got %h",
                             $time, due.lane_index, due.lane_sum, res.lane_sum);
                end
                if (res.last_lane !== due.last_lane)
                begin
                    errors++;
                    $display("%0t: lane %0d last_lane expected %b got %b",
                             $time, due.lane_index, due.last_lane, res.last_lane);
                end
            end
        end
    end

    // hang guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int  sent;
        int  run_len;
        bit  heavy;
        bit  long_done;
        sent      = 0;
        long_done = 1'b0;
        foreach (lane_totals[k])
            lane_totals[k] = '0;

        // directed rows: typed sums where they follow from the segment alone
        // all zero right after reset
        add_row('0, '0, '0, '0, 1'b1, 1'b1, 16'h0000, 16'h0000);
        // all ones everywhere: every lane picks byte 15 = 0xff
        add_row('1, '1, '1, '1, 1'b1, 1'b1, 16'h00FF, 16'h00FF);
        // ramp table 0x00..0xff; codes 0xf0 split lanes between byte 0 and byte 15
        add_row(64'h7766_5544_3322_1100, 64'hFFEE_DDCC_BBAA_9988,
                {8{8'hF0}}, {8{8'hF0}}, 1'b1, 1'b1, 16'h0000, 16'h00FF);
        add_row(64'h7766_5544_3322_1100, 64'hFFEE_DDCC_BBAA_9988,
                {8{8'h0F}}, {8{8'h0F}}, 1'b1, 1'b1, 16'h00FF, 16'h0000);
        // byte 0 and byte 15 stand out from the rest
        add_row(64'h3C3C_3C3C_3C3C_3CA5, 64'h5AC3_C3C3_C3C3_C3C3,
                '0, '0, 1'b1, 1'b1, 16'h00A5, 16'h00A5);
        add_row(64'h3C3C_3C3C_3C3C_3CA5, 64'h5AC3_C3C3_C3C3_C3C3,
                '1, '1, 1'b1, 1'b1, 16'h005A, 16'h005A);
        // multi-segment run, every nibble value on both halves
        add_row(64'h7766_5544_3322_1100, 64'hFFEE_DDCC_BBAA_9988,
                64'hEFCD_AB89_6745_2301, 64'h1032_5476_98BA_DCFE, 1'b0, 1'b0, '0, '0);
        add_row(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF, 1'b0, 1'b0, '0, '0);
        add_row(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, 1'b0, '0, '0);
        add_row(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, '0, '0);
        add_row('1, '1, 64'h1E2D_3C4B_5A69_7887, 64'h96A5_B4C3_D2E1_F00F,
                1'b1, 1'b0, '0, '0);
        // back-to-back last segments: each waits on the output bank
        add_row(64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A,
                64'h5A5A_5A5A_5A5A_5A5A, 64'hA5A5_A5A5_A5A5_A5A5, 1'b1, 1'b0, '0, '0);
        add_row(64'h8040_2010_0804_0201, 64'h0102_0408_1020_4080,
                64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF, 1'b1, 1'b0, '0, '0);
        add_row(64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF,
                64'h7788_6699_55AA_44BB, 64'h33CC_22DD_11EE_00FF, 1'b1, 1'b0, '0, '0);

        // single reset at the start, released on a falling edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
            send_word(plan[i].word, plan[i].typed, plan[i].low_half_sum,
                      plan[i].high_half_sum);

        // random runs: a run is some non-last segments closed by a last one;
        // a zero-length run gives back-to-back last segments, and one long
        // run of large table bytes pushes every lane past the 16-bit wrap
        while (sent < RANDOM_ITEMS)
        begin
            run_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            heavy   = 1'b0;
            if (!long_done && sent >= 40)
            begin
                run_len   = LONG_RUN;
                heavy     = 1'b1;
                long_done = 1'b1;
            end
            repeat (run_len)
            begin
                send_word(random_segment(1'b0, heavy), 1'b0, '0, '0);
                sent++;
            end
            send_word(random_segment(1'b1, heavy), 1'b0, '0, '0);
            sent++;
        end
        seg_valid <= 1'b0;

        // let the output bank drain, then watch for stray words
        while (lane_sums_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
